// ----- hw/rtl/cpt_pkg.sv -----
// Shared types, codes and helpers of the congestion phase tracker.
package cpt_pkg;

	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned RUN_W   = 16;
	localparam int unsigned LIMIT_W = 4;
	localparam int unsigned IN_TDATA_W  = 136;
	localparam int unsigned OUT_TDATA_W = 184;

	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_RECOV = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_ACK     = 2'd0,
		EV_WINDOW  = 2'd1,
		EV_THRESH  = 2'd2,
		EV_TIMEOUT = 2'd3
	} mode_t;

	typedef enum logic {
		REG_DUP_ACK_LIMIT  = 1'b0,
		REG_INIT_THRESHOLD = 1'b1
	} reg_index_t;

	localparam logic [LIMIT_W-1:0] DUP_ACK_LIMIT_RST = 4'd3;
	localparam logic [SEQ_W-1:0]   INIT_THRESHOLD_RST = 32'hFFFF_FFFF;

	typedef struct packed {
		mode_t            mode;
		logic             has_ack;
		logic [SEQ_W-1:0] ack_number;
		logic [SEQ_W-1:0] window_bytes;
		logic [SEQ_W-1:0] old_timeout_us;
		logic [SEQ_W-1:0] new_timeout_us;
	} event_t;

	typedef struct packed {
		logic             we;
		reg_index_t       index;
		logic [SEQ_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] fast_retransmit_total;
		logic [CNT_W-1:0] timeout_total;
		logic [CNT_W-1:0] dup_ack_total;
		logic [CNT_W-1:0] phase_change_total;
		logic             timeout_now;
		logic             fast_retransmit_now;
		logic [RUN_W-1:0] dup_run;
		logic [SEQ_W-1:0] threshold_now;
		logic             phase_changed;
		phase_t           phase;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

endpackage

// ----- hw/rtl/cpt_engine.sv -----
// Congestion state registers and the per-transaction update logic.
module cpt_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  cpt_pkg::event_t  evt,
	input  cpt_pkg::cfg_wr_t cfg,
	output cpt_pkg::result_t res
);

	cpt_pkg::phase_t                phase_q, phase_d;
	logic [cpt_pkg::SEQ_W-1:0]      last_ack_q, last_ack_d;
	logic [cpt_pkg::RUN_W-1:0]      dup_count_q, dup_count_d, dup_inc;
	logic [cpt_pkg::SEQ_W-1:0]      threshold_q, threshold_d;
	logic [cpt_pkg::SEQ_W-1:0]      last_window_q, last_window_d;
	logic [cpt_pkg::CNT_W-1:0]      change_cnt_q, change_cnt_d;
	logic [cpt_pkg::CNT_W-1:0]      dup_cnt_q, dup_cnt_d;
	logic [cpt_pkg::CNT_W-1:0]      timeout_cnt_q, timeout_cnt_d;
	logic [cpt_pkg::CNT_W-1:0]      retx_cnt_q, retx_cnt_d;
	logic [cpt_pkg::LIMIT_W-1:0]    limit_q;
	logic [cpt_pkg::SEQ_W+1:0]      rto_new_x2, rto_old_x3;
	logic                           fr_now, to_now, is_dup;
	cpt_pkg::phase_t                target;

	assign rto_new_x2 = {1'b0, evt.new_timeout_us, 1'b0};
	assign rto_old_x3 = {1'b0, evt.old_timeout_us, 1'b0} + {2'b00, evt.old_timeout_us};
	assign is_dup     = (evt.ack_number == last_ack_q) && (|evt.ack_number);
	assign dup_inc    = (&dup_count_q) ? dup_count_q : dup_count_q + 1'b1;

	always_comb begin
		target        = phase_q;
		last_ack_d    = last_ack_q;
		dup_count_d   = dup_count_q;
		threshold_d   = threshold_q;
		last_window_d = last_window_q;
		dup_cnt_d     = dup_cnt_q;
		timeout_cnt_d = timeout_cnt_q;
		retx_cnt_d    = retx_cnt_q;
		fr_now        = 1'b0;
		to_now        = 1'b0;
		case (evt.mode)
			cpt_pkg::EV_ACK: begin
				if (evt.has_ack) begin
					if (is_dup) begin
						dup_count_d = dup_inc;
						dup_cnt_d   = cpt_pkg::sat_inc(dup_cnt_q);
						if (dup_inc == {{(cpt_pkg::RUN_W-cpt_pkg::LIMIT_W){1'b0}}, limit_q} &&
						    phase_q != cpt_pkg::PH_RECOV) begin
							target      = cpt_pkg::PH_RECOV;
							threshold_d = last_window_q >> 1;
							retx_cnt_d  = cpt_pkg::sat_inc(retx_cnt_q);
							fr_now      = 1'b1;
						end
					end else if (evt.ack_number > last_ack_q) begin
						last_ack_d  = evt.ack_number;
						dup_count_d = '0;
						if (phase_q == cpt_pkg::PH_RECOV)
							target = cpt_pkg::PH_AVOID;
					end
				end
			end
			cpt_pkg::EV_WINDOW: begin
				if (phase_q == cpt_pkg::PH_SLOW && evt.window_bytes >= threshold_q) begin
					target      = cpt_pkg::PH_AVOID;
					dup_count_d = '0;
				end
				last_window_d = evt.window_bytes;
			end
			cpt_pkg::EV_THRESH: begin
				threshold_d = evt.window_bytes;
			end
			cpt_pkg::EV_TIMEOUT: begin
				if (rto_new_x2 > rto_old_x3) begin
					to_now        = 1'b1;
					threshold_d   = last_window_q >> 1;
					dup_count_d   = '0;
					timeout_cnt_d = cpt_pkg::sat_inc(timeout_cnt_q);
					target        = cpt_pkg::PH_SLOW;
				end
			end
			default: ;
		endcase
		phase_d      = target;
		change_cnt_d = (target != phase_q) ? cpt_pkg::sat_inc(change_cnt_q) : change_cnt_q;
	end

	always_comb begin
		res.phase                 = phase_d;
		res.phase_changed         = (phase_d != phase_q);
		res.threshold_now         = threshold_d;
		res.dup_run               = dup_count_d;
		res.fast_retransmit_now   = fr_now;
		res.timeout_now           = to_now;
		res.phase_change_total    = change_cnt_d;
		res.dup_ack_total         = dup_cnt_d;
		res.timeout_total         = timeout_cnt_d;
		res.fast_retransmit_total = retx_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= cpt_pkg::PH_SLOW;
			last_ack_q    <= '0;
			dup_count_q   <= '0;
			threshold_q   <= cpt_pkg::INIT_THRESHOLD_RST;
			last_window_q <= '0;
			change_cnt_q  <= '0;
			dup_cnt_q     <= '0;
			timeout_cnt_q <= '0;
			retx_cnt_q    <= '0;
			limit_q       <= cpt_pkg::DUP_ACK_LIMIT_RST;
		end else begin
			if (cfg.we && cfg.index == cpt_pkg::REG_DUP_ACK_LIMIT)
				limit_q <= cfg.data[cpt_pkg::LIMIT_W-1:0];
			if (cfg.we && cfg.index == cpt_pkg::REG_INIT_THRESHOLD) begin
				threshold_q <= cfg.data;
			end else if (step) begin
				threshold_q <= threshold_d;
			end
			if (step) begin
				phase_q       <= phase_d;
				last_ack_q    <= last_ack_d;
				dup_count_q   <= dup_count_d;
				last_window_q <= last_window_d;
				change_cnt_q  <= change_cnt_d;
				dup_cnt_q     <= dup_cnt_d;
				timeout_cnt_q <= timeout_cnt_d;
				retx_cnt_q    <= retx_cnt_d;
			end
		end
	end

	// fast retransmit always lands in recovery
	a_fr_recov: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.fast_retransmit_now |-> res.phase == cpt_pkg::PH_RECOV)
		else $error("fast retransmit without recovery");

	// a timeout backoff always lands in slow start
	a_to_slow: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.timeout_now |-> res.phase == cpt_pkg::PH_SLOW)
		else $error("timeout without slow start");

	// a phase change is counted unless the counter is saturated
	a_chg_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.phase_changed && !(&change_cnt_q) |=> change_cnt_q == $past(change_cnt_q) + 1'b1)
		else $error("phase change not counted");

	// phase, duplicate total and last ack only move when a transaction is processed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(dup_cnt_q) && $stable(last_ack_q))
		else $error("state moved without a transaction");

endmodule

// ----- hw/rtl/tcp_congestion_phase_tracker.sv -----
// Top level of the congestion phase tracker: stream ports, input and result registers.
//
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------------
// s_       | in  | s_tvalid / s_tready    | s_tuser: mode; s_tdata: event fields
// m_       | out | m_tvalid / m_tready    | m_tdata: phase, flags, threshold, counters
// cfg_     | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
// Each transaction passes through the input register, then the update logic and
// the result register. One transaction per cycle is sustained while m_tready is
// high; the congestion state is updated as the result is registered, so the next
// transaction in the input register sees it. Reset clears the state, loads the
// threshold with all ones and the duplicate limit with 3. A stall on m_tready
// holds the result register and backs up into the input register; s_tready
// stays high while the result register is being drained.
module tcp_congestion_phase_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [0] has_ack, [32:1] ack_number, [64:33] window_bytes,
	// [96:65] old_timeout_us, [128:97] new_timeout_us, [135:129] zero
	input  logic [cpt_pkg::IN_TDATA_W-1:0]      s_tdata,
	// [1:0] mode
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] phase, [2] phase_changed, [34:3] threshold_now, [50:35] dup_run,
	// [51] fast_retransmit_now, [52] timeout_now, [84:53] phase_change_total,
	// [116:85] dup_ack_total, [148:117] timeout_total,
	// [180:149] fast_retransmit_total, [183:181] zero
	output logic [cpt_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [cpt_pkg::SEQ_W-1:0]           cfg_data
);

	cpt_pkg::event_t  evt_s1;
	logic             valid_s1;
	logic             advance;
	cpt_pkg::result_t res;
	cpt_pkg::result_t res_q;
	logic             m_valid_q;
	cpt_pkg::cfg_wr_t cfg;

	// input register moves on when the result register is empty or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign cfg.we    = cfg_we;
	assign cfg.index = cpt_pkg::reg_index_t'(cfg_index);
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			evt_s1.mode           <= cpt_pkg::mode_t'(s_tuser);
			evt_s1.has_ack        <= s_tdata[0];
			evt_s1.ack_number     <= s_tdata[32:1];
			evt_s1.window_bytes   <= s_tdata[64:33];
			evt_s1.old_timeout_us <= s_tdata[96:65];
			evt_s1.new_timeout_us <= s_tdata[128:97];
		end
	end

	cpt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.evt    (evt_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, res_q};

endmodule
